// ===== src/gdd_pkg.sv =====
package gdd_pkg;

  // Field widths of the date and count beats
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;

  // Accumulator: signed, wide enough for every year of a 14-bit span plus margin
  localparam int unsigned ACC_W = 25;
  // Year position inside the 400-year Gregorian cycle
  localparam int unsigned MOD_W = 9;
  // Day of year, invalid days included (at most 397)
  localparam int unsigned ORD_W = 9;

  localparam logic [ACC_W-1:0]   YEAR_CYCLE = ACC_W'(400);
  localparam logic [MOD_W-1:0]   CYCLE_LAST = MOD_W'(399);
  localparam logic [ACC_W-1:0]   DAYS_YEAR  = ACC_W'(365);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

  localparam logic [MONTH_W-1:0] MONTH_MARCH = MONTH_W'(3);

  // Request to the shared add/subtract unit
  typedef struct packed {
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic             sub;
  } alu_req_t;

  // Days before the first of a month in a common year; month 0 sums nothing,
  // months past December sum all twelve
  function automatic logic [ORD_W-1:0] days_before(input logic [MONTH_W-1:0] month);
    logic [ORD_W-1:0] days;
    unique case (month)
      4'd0, 4'd1: days = ORD_W'(0);
      4'd2:       days = ORD_W'(31);
      4'd3:       days = ORD_W'(59);
      4'd4:       days = ORD_W'(90);
      4'd5:       days = ORD_W'(120);
      4'd6:       days = ORD_W'(151);
      4'd7:       days = ORD_W'(181);
      4'd8:       days = ORD_W'(212);
      4'd9:       days = ORD_W'(243);
      4'd10:      days = ORD_W'(273);
      4'd11:      days = ORD_W'(304);
      4'd12:      days = ORD_W'(334);
      default:    days = ORD_W'(365);
    endcase
    return days;
  endfunction

  // Leap test from the year's place in the 400-year cycle
  function automatic logic is_leap(input logic [MOD_W-1:0] pos);
    return (pos[1:0] == 2'b00) && (pos != MOD_W'(100)) && (pos != MOD_W'(200)) &&
           (pos != MOD_W'(300));
  endfunction

endpackage

// ===== src/gdd_dates_if.sv =====
interface gdd_dates_if;
  logic                          valid;
  logic                          ready;
  logic [gdd_pkg::YEAR_W-1:0]    first_year;
  logic [gdd_pkg::MONTH_W-1:0]   first_month;
  logic [gdd_pkg::DAY_W-1:0]     first_day;
  logic [gdd_pkg::YEAR_W-1:0]    second_year;
  logic [gdd_pkg::MONTH_W-1:0]   second_month;
  logic [gdd_pkg::DAY_W-1:0]     second_day;

  modport source (
    output valid, first_year, first_month, first_day, second_year, second_month, second_day,
    input  ready
  );
  modport sink (
    input  valid, first_year, first_month, first_day, second_year, second_month, second_day,
    output ready
  );
endinterface

// ===== src/gdd_count_if.sv =====
interface gdd_count_if;
  logic                          valid;
  logic                          ready;
  logic [gdd_pkg::COUNT_W-1:0]   day_count;

  modport source (
    output valid, day_count,
    input  ready
  );
  modport sink (
    input  valid, day_count,
    output ready
  );
endinterface

// ===== src/gdd_alu.sv =====
module gdd_alu (
  input  gdd_pkg::alu_req_t           req_i,
  output logic [gdd_pkg::ACC_W-1:0]   res_o
);

  // Add or subtract; the top bit of the result is the sign
  assign res_o = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);

endmodule

// ===== src/gdd_ordinal.sv =====
module gdd_ordinal (
  input  logic [gdd_pkg::MONTH_W-1:0] month_i,
  input  logic [gdd_pkg::DAY_W-1:0]   day_i,
  input  logic                        leap_i,
  output logic [gdd_pkg::ORD_W-1:0]   ordinal_o
);

  logic feb_extra;

  // Add February 29 for any month after February in a leap year
  assign feb_extra = leap_i && (month_i >= gdd_pkg::MONTH_MARCH);

  assign ordinal_o = gdd_pkg::days_before(month_i)
                   + gdd_pkg::ORD_W'(day_i)
                   + gdd_pkg::ORD_W'(feb_extra);

endmodule

// ===== src/gregorian_date_difference_unit.sv =====
// A pair is taken only in idle; the sequencer then steps through reduce, subtract-first,
// years, add-second and finish, where it loads the count beat once the register is free.
// One shared adder first reduces the earlier year modulo 400 by repeated subtraction, then
// adds 365 or 366 for one year per cycle.
// The count sits in an output register, so the next pair is taken while it waits.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops the count beat.
module gregorian_date_difference_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  gdd_dates_if.sink         dates_i,
  gdd_count_if.source       count_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SUB_FIRST,
    ST_YEARS,
    ST_ADD_SECOND,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic [gdd_pkg::COUNT_W-1:0] out_q, out_d;

  logic [gdd_pkg::YEAR_W-1:0]  y_lo_q, y_lo_d, y_hi_q, y_hi_d;
  logic [gdd_pkg::MONTH_W-1:0] m_lo_q, m_lo_d, m_hi_q, m_hi_d;
  logic [gdd_pkg::DAY_W-1:0]   d_lo_q, d_lo_d, d_hi_q, d_hi_d;
  logic [gdd_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic [gdd_pkg::MOD_W-1:0]   pos_q, pos_d;

  logic                        accept;
  logic                        swap;
  logic                        leap;
  logic                        use_lo;
  logic [gdd_pkg::ORD_W-1:0]   ordinal;
  gdd_pkg::alu_req_t           alu_req;
  logic [gdd_pkg::ACC_W-1:0]   alu_res;

  assign dates_i.ready = (state_q == ST_IDLE);
  assign accept        = dates_i.valid && dates_i.ready;
  assign count_o.valid = out_valid_q;
  assign count_o.day_count = out_q;

  // Order the pair by year, month, day
  assign swap = {dates_i.first_year, dates_i.first_month, dates_i.first_day} >
                {dates_i.second_year, dates_i.second_month, dates_i.second_day};

  assign leap   = gdd_pkg::is_leap(pos_q);
  assign use_lo = (state_q == ST_SUB_FIRST);

  gdd_ordinal u_ordinal (
    .month_i   (use_lo ? m_lo_q : m_hi_q),
    .day_i     (use_lo ? d_lo_q : d_hi_q),
    .leap_i    (leap),
    .ordinal_o (ordinal)
  );

  // Pick the operands of the shared adder for this step
  always_comb begin
    alu_req = '0;
    unique case (state_q)
      ST_REDUCE: begin
        alu_req.a   = acc_q;
        alu_req.b   = gdd_pkg::YEAR_CYCLE;
        alu_req.sub = 1'b1;
      end
      ST_SUB_FIRST: begin
        alu_req.a   = acc_q;
        alu_req.b   = gdd_pkg::ACC_W'(ordinal);
        alu_req.sub = 1'b1;
      end
      ST_YEARS: begin
        alu_req.a   = acc_q;
        alu_req.b   = gdd_pkg::DAYS_YEAR + gdd_pkg::ACC_W'(leap);
        alu_req.sub = 1'b0;
      end
      ST_ADD_SECOND: begin
        alu_req.a   = acc_q;
        alu_req.b   = gdd_pkg::ACC_W'(ordinal);
        alu_req.sub = 1'b0;
      end
      default: alu_req = '0;
    endcase
  end

  gdd_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // Sequencer and datapath next values
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    y_lo_d = y_lo_q;
    y_hi_d = y_hi_q;
    m_lo_d = m_lo_q;
    m_hi_d = m_hi_q;
    d_lo_d = d_lo_q;
    d_hi_d = d_hi_q;
    acc_d  = acc_q;
    pos_d  = pos_q;

    // Drop the count beat once taken
    if (out_valid_q && count_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (swap) begin
            y_lo_d = dates_i.second_year;
            m_lo_d = dates_i.second_month;
            d_lo_d = dates_i.second_day;
            y_hi_d = dates_i.first_year;
            m_hi_d = dates_i.first_month;
            d_hi_d = dates_i.first_day;
            acc_d  = gdd_pkg::ACC_W'(dates_i.second_year);
          end else begin
            y_lo_d = dates_i.first_year;
            m_lo_d = dates_i.first_month;
            d_lo_d = dates_i.first_day;
            y_hi_d = dates_i.second_year;
            m_hi_d = dates_i.second_month;
            d_hi_d = dates_i.second_day;
            acc_d  = gdd_pkg::ACC_W'(dates_i.first_year);
          end
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        // Subtract 400 until it would go negative; the rest is the cycle position
        if (alu_res[gdd_pkg::ACC_W-1]) begin
          pos_d   = acc_q[gdd_pkg::MOD_W-1:0];
          acc_d   = '0;
          state_d = ST_SUB_FIRST;
        end else begin
          acc_d = alu_res;
        end
      end
      ST_SUB_FIRST: begin
        acc_d   = alu_res;
        state_d = ST_YEARS;
      end
      ST_YEARS: begin
        // Until the years meet, add one whole year and advance the year and its cycle position
        if (y_lo_q == y_hi_q) begin
          state_d = ST_ADD_SECOND;
        end else begin
          acc_d  = alu_res;
          y_lo_d = y_lo_q + gdd_pkg::YEAR_W'(1);
          pos_d  = (pos_q == gdd_pkg::CYCLE_LAST) ? '0 : pos_q + gdd_pkg::MOD_W'(1);
        end
      end
      ST_ADD_SECOND: begin
        acc_d   = alu_res;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // Clamp into the count range once the output register is free
        if (!out_valid_q || count_o.ready) begin
          priority if (acc_q[gdd_pkg::ACC_W-1]) begin
            out_d = '0;
          end else if (acc_q[gdd_pkg::ACC_W-2:gdd_pkg::COUNT_W] != '0) begin
            out_d = gdd_pkg::COUNT_MAX;
          end else begin
            out_d = acc_q[gdd_pkg::COUNT_W-1:0];
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and the count beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // Hold the working dates and accumulator
  always_ff @(posedge clk_i) begin
    y_lo_q <= y_lo_d;
    y_hi_q <= y_hi_d;
    m_lo_q <= m_lo_d;
    m_hi_q <= m_hi_d;
    d_lo_q <= d_lo_d;
    d_hi_q <= d_hi_d;
    acc_q  <= acc_d;
    pos_q  <= pos_d;
  end

  a_accept_starts_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_REDUCE))
    else $error("accepted dates did not start the year reduction");

  a_years_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_YEARS) |-> (y_lo_q <= y_hi_q))
    else $error("year walk passed the later year");

  a_pos_in_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUB_FIRST || state_q == ST_YEARS || state_q == ST_ADD_SECOND) |->
    (pos_q <= gdd_pkg::CYCLE_LAST))
    else $error("cycle position out of range");

  a_year_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_YEARS && y_lo_q != y_hi_q) |=>
    (state_q == ST_YEARS && y_lo_q == $past(y_lo_q) + gdd_pkg::YEAR_W'(1)))
    else $error("year walk did not advance by one");

  a_finish_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished count not loaded into the output register");

endmodule
